@@ rtl/hpid_pkg.sv @@
// ----------------------------------------------------------------------------
// hpid_pkg
// Shared widths, constants, register indexes and reset values for the
// heading PID turn controller.
// ----------------------------------------------------------------------------
package hpid_pkg;

  // field widths
  localparam int HEADING_W = 16;
  localparam int TIME_W    = 32;
  localparam int GAIN_W    = 24;
  localparam int MAG_W     = 15;
  localparam int WIN_W     = 7;
  localparam int LIMIT_W   = 20;
  localparam int DRIVE_W   = 15;
  localparam int ERR_W     = 16;

  // angles in hundredths of a degree, drive in hundredths of a percent
  localparam int HEADING_MOD = 36000;
  localparam int HALF_TURN   = 18000;
  localparam int DRIVE_MAX   = 10000;

  localparam int GAIN_FRAC_BITS  = 16;
  localparam int DERIV_FRAC_BITS = 8;

  localparam int WINDOW_MAX_DEF = 64;

  // iterative divider for the derivative term
  localparam int DIV_NUM_W = 24;
  localparam int DIV_DEN_W = TIME_W;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET = 3'd0,
    REG_KP     = 3'd1,
    REG_KI     = 3'd2,
    REG_KD     = 3'd3,
    REG_IZONE  = 3'd4,
    REG_SETTLE = 3'd5,
    REG_WINDOW = 3'd6,
    REG_TLIMIT = 3'd7
  } cfg_reg_t;

  // register reset values
  localparam logic [HEADING_W-1:0]     TARGET_RST = 16'd0;
  localparam logic signed [GAIN_W-1:0] KP_RST     = 24'sd50463;
  localparam logic signed [GAIN_W-1:0] KI_RST     = 24'sd92;
  localparam logic signed [GAIN_W-1:0] KD_RST     = 24'sd12452;
  localparam logic [MAG_W-1:0]         IZONE_RST  = 15'd1500;
  localparam logic [MAG_W-1:0]         SETTLE_RST = 15'd500;
  localparam logic [WIN_W-1:0]         WINDOW_RST = 7'd10;
  localparam logic [LIMIT_W-1:0]       TLIMIT_RST = 20'd3000;

endpackage

@@ rtl/hpid_if.sv @@
// ----------------------------------------------------------------------------
// hpid channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface hpid_sample_if;
  logic                             valid;
  logic                             ready;
  logic                             begin_req;
  logic [hpid_pkg::HEADING_W-1:0]   heading;
  logic [hpid_pkg::TIME_W-1:0]      timestamp_ms;

  modport source (output valid, begin_req, heading, timestamp_ms, input ready);
  modport sink   (input valid, begin_req, heading, timestamp_ms, output ready);
endinterface

interface hpid_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [hpid_pkg::DRIVE_W-1:0] drive;
  logic signed [hpid_pkg::ERR_W-1:0]   heading_error;
  logic                             done_res;
  logic                             timed_out;

  modport source (output valid, drive, heading_error, done_res, timed_out, input ready);
  modport sink   (input valid, drive, heading_error, done_res, timed_out, output ready);
endinterface

interface hpid_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [hpid_pkg::CFG_IDX_W-1:0]    index;
  logic [hpid_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/hpid_div.sv @@
// ----------------------------------------------------------------------------
// hpid_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hpid_div #(
  parameter int NUM_W = hpid_pkg::DIV_NUM_W,
  parameter int DEN_W = hpid_pkg::DIV_DEN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot,
  output logic             busy
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] num_sh;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             ge;

  assign trial     = {rem, num_sh[NUM_W-1]};
  assign trial_sub = trial - {1'b0, den_r};
  assign ge        = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= '0;
      num_sh <= num;
      den_r  <= den;
      quot   <= '0;
    end else if (busy) begin
      // remainder stays below den, so the top bit drops out
      rem    <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
      quot   <= {quot[NUM_W-2:0], ge};
    end
  end

endmodule

@@ rtl/heading_pid_turn_controller.sv @@
// ----------------------------------------------------------------------------
// heading_pid_turn_controller
// Heading PID with integral zone, settle window and time limit.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  cfg       in   valid/ready   index, data
//  samples   in   valid/ready   begin_req, heading, timestamp_ms
//  results   out  valid/ready   drive, heading_error, done_res, timed_out
//
//  A sample's result is loaded once the sequencer has waited in DWAIT for the
//  derivative divider; one shared 24x33 multiplier forms the integral step and
//  the three gain products in turn. No beat is taken until the result loads.
//  samples.ready is high only while the sequencer is idle; the output register
//  lets the next sample start while a result waits. cfg is always ready.
//  rst is synchronous and restores register defaults and zeroed turn state.
// ----------------------------------------------------------------------------
module heading_pid_turn_controller #(
  parameter int WINDOW_MAX = hpid_pkg::WINDOW_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst,
  hpid_cfg_if.sink      cfg,
  hpid_sample_if.sink   samples,
  hpid_result_if.source results
);

  localparam int CW    = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W = (CW > hpid_pkg::WIN_W) ? CW : hpid_pkg::WIN_W;
  localparam logic [CW-1:0]    WMAX_C   = CW'(WINDOW_MAX);
  localparam logic [CMP_W-1:0] WMAX_CMP = CMP_W'(WINDOW_MAX);

  localparam int SHIFT = hpid_pkg::GAIN_FRAC_BITS + hpid_pkg::DERIV_FRAC_BITS;
  localparam logic [63:0] HALF_LSB = 64'd1 << (SHIFT - 1);
  localparam int DMAG_W = hpid_pkg::DRIVE_W - 1;

  localparam logic [hpid_pkg::HEADING_W-1:0] MOD16 =
    hpid_pkg::HEADING_W'(hpid_pkg::HEADING_MOD);
  localparam logic signed [16:0] HALF17 = 17'(hpid_pkg::HALF_TURN);
  localparam logic signed [16:0] MOD17  = 17'(hpid_pkg::HEADING_MOD);
  localparam logic signed [57:0] ISUM_MAX = {26'd0, 32'h7FFF_FFFF};
  localparam logic signed [57:0] ISUM_MIN = {{26{1'b1}}, 32'h8000_0000};

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_ERR   = 10'b00_0000_0010,
    S_DIFF  = 10'b00_0000_0100,
    S_INTEG = 10'b00_0000_1000,
    S_PTERM = 10'b00_0001_0000,
    S_ITERM = 10'b00_0010_0000,
    S_DWAIT = 10'b00_0100_0000,
    S_DTERM = 10'b00_1000_0000,
    S_MAG   = 10'b01_0000_0000,
    S_ROUND = 10'b10_0000_0000
  } state_t;

  state_t state;

  // configuration registers
  logic [hpid_pkg::HEADING_W-1:0]     target;
  logic signed [hpid_pkg::GAIN_W-1:0] kp;
  logic signed [hpid_pkg::GAIN_W-1:0] ki;
  logic signed [hpid_pkg::GAIN_W-1:0] kd;
  logic [hpid_pkg::MAG_W-1:0]         izone;
  logic [hpid_pkg::MAG_W-1:0]         sthr;
  logic [hpid_pkg::WIN_W-1:0]         winlen;
  logic [hpid_pkg::LIMIT_W-1:0]       tlimit;

  // turn state
  logic signed [hpid_pkg::ERR_W-1:0]  prev_err;
  logic [hpid_pkg::TIME_W-1:0]        prev_time;
  logic [hpid_pkg::TIME_W-1:0]        turn_start;
  logic signed [31:0]                 isum;
  logic [CW-1:0]                      settled_count;

  // per-sample working registers
  logic [hpid_pkg::HEADING_W-1:0]     heading_r;
  logic [hpid_pkg::TIME_W-1:0]        ts_r;
  logic signed [hpid_pkg::ERR_W-1:0]  err_r;
  logic [hpid_pkg::MAG_W-1:0]         mag_e_r;
  logic [hpid_pkg::TIME_W-1:0]        dt_r;
  logic                               dsign;
  logic                               dt_zero;
  logic                               done_r;
  logic                               timed_r;
  logic signed [56:0]                 prod;
  logic signed [63:0]                 total;
  logic [63:0]                        mag;
  logic                               neg;

  // output register
  logic                               out_valid;
  logic signed [hpid_pkg::DRIVE_W-1:0] drive_q;
  logic signed [hpid_pkg::ERR_W-1:0]  err_q;
  logic                               done_q;
  logic                               timed_q;

  // combinational
  logic [hpid_pkg::HEADING_W-1:0]     hd_m;
  logic [hpid_pkg::HEADING_W-1:0]     tg_m;
  logic signed [16:0]                 raw;
  logic signed [16:0]                 wrapped;
  logic [hpid_pkg::MAG_W-1:0]         err_abs;
  logic signed [16:0]                 diff;
  logic [15:0]                        diff_abs;
  logic [hpid_pkg::DIV_NUM_W-1:0]     div_num;
  logic [hpid_pkg::DIV_NUM_W-1:0]     div_quot;
  logic                               div_busy;
  logic                               div_start;
  logic [hpid_pkg::DIV_NUM_W:0]       q_ext;
  logic signed [hpid_pkg::DIV_NUM_W:0] dfix;
  logic signed [23:0]                 mul_a;
  logic signed [32:0]                 mul_b;
  logic signed [57:0]                 acc;
  logic signed [31:0]                 isum_sat;
  logic                               settled;
  logic [CW-1:0]                      count_next;
  logic [CMP_W-1:0]                   win_ext;
  logic [CMP_W-1:0]                   win;
  logic [hpid_pkg::TIME_W-1:0]        elapsed;
  logic                               timed;
  logic [63:0]                        r_full;
  logic [DMAG_W-1:0]                  drive_mag;
  logic signed [hpid_pkg::DRIVE_W-1:0] drive_val;
  logic                               out_load;

  // ---------------- error and wrap ----------------
  always_comb begin
    hd_m = (heading_r >= MOD16) ? heading_r - MOD16 : heading_r;
    tg_m = (target >= MOD16) ? target - MOD16 : target;
    raw  = $signed({1'b0, tg_m}) - $signed({1'b0, hd_m});
    if (raw > HALF17) begin
      wrapped = raw - MOD17;
    end else if (raw < -HALF17) begin
      wrapped = raw + MOD17;
    end else begin
      wrapped = raw;
    end
    err_abs = wrapped[16] ? hpid_pkg::MAG_W'(-wrapped) : hpid_pkg::MAG_W'(wrapped);
  end

  // ---------------- derivative divider ----------------
  assign diff      = $signed({err_r[15], err_r}) - $signed({prev_err[15], prev_err});
  assign diff_abs  = diff[16] ? 16'(-diff) : 16'(diff);
  assign div_num   = {diff_abs, 8'd0};
  assign div_start = (state == S_DIFF);

  hpid_div #(
    .NUM_W (hpid_pkg::DIV_NUM_W),
    .DEN_W (hpid_pkg::DIV_DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (dt_r),
    .quot  (div_quot),
    .busy  (div_busy)
  );

  assign q_ext = {1'b0, div_quot};
  assign dfix  = dt_zero ? '0 : (dsign ? $signed(-q_ext) : $signed(q_ext));

  // ---------------- shared multiplier operand select ----------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_DIFF: begin
        mul_a = {{8{err_r[15]}}, err_r};
        mul_b = {1'b0, dt_r};
      end
      S_INTEG: begin
        mul_a = kp;
        mul_b = {{9{err_r[15]}}, err_r, 8'd0};
      end
      S_PTERM: begin
        mul_a = ki;
        mul_b = {isum[31], isum};
      end
      S_DWAIT: begin
        mul_a = kd;
        mul_b = {{8{dfix[hpid_pkg::DIV_NUM_W]}}, dfix};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---------------- integral, settle window, time limit ----------------
  always_comb begin
    acc = {{26{isum[31]}}, isum} + {prod[56], prod};
    if (acc > ISUM_MAX) begin
      isum_sat = 32'sh7FFF_FFFF;
    end else if (acc < ISUM_MIN) begin
      isum_sat = 32'sh8000_0000;
    end else begin
      isum_sat = acc[31:0];
    end

    settled = (mag_e_r < sthr);
    if (settled) begin
      count_next = (settled_count < WMAX_C) ? settled_count + 1'b1 : settled_count;
    end else begin
      count_next = '0;
    end

    win_ext = CMP_W'(winlen);
    if (win_ext == '0) begin
      win = CMP_W'(1);
    end else if (win_ext > WMAX_CMP) begin
      win = WMAX_CMP;
    end else begin
      win = win_ext;
    end

    elapsed = ts_r - turn_start;
    timed   = (elapsed > hpid_pkg::TIME_W'(tlimit));
  end

  // ---------------- rounding and drive clamp ----------------
  always_comb begin
    r_full    = (mag + HALF_LSB) >> SHIFT;
    drive_mag = (r_full > 64'(hpid_pkg::DRIVE_MAX)) ? DMAG_W'(hpid_pkg::DRIVE_MAX)
                                                    : r_full[DMAG_W-1:0];
    drive_val = neg ? $signed(-{1'b0, drive_mag}) : $signed({1'b0, drive_mag});
  end

  assign out_load = (state == S_ROUND) && (!out_valid || results.ready);

  // ---------------- control and turn state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      target        <= hpid_pkg::TARGET_RST;
      kp            <= hpid_pkg::KP_RST;
      ki            <= hpid_pkg::KI_RST;
      kd            <= hpid_pkg::KD_RST;
      izone         <= hpid_pkg::IZONE_RST;
      sthr          <= hpid_pkg::SETTLE_RST;
      winlen        <= hpid_pkg::WINDOW_RST;
      tlimit        <= hpid_pkg::TLIMIT_RST;
      prev_err      <= '0;
      prev_time     <= '0;
      turn_start    <= '0;
      isum          <= '0;
      settled_count <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (hpid_pkg::cfg_reg_t'(cfg.index))
          hpid_pkg::REG_TARGET: target <= cfg.data[hpid_pkg::HEADING_W-1:0];
          hpid_pkg::REG_KP:     kp     <= cfg.data[hpid_pkg::GAIN_W-1:0];
          hpid_pkg::REG_KI:     ki     <= cfg.data[hpid_pkg::GAIN_W-1:0];
          hpid_pkg::REG_KD:     kd     <= cfg.data[hpid_pkg::GAIN_W-1:0];
          hpid_pkg::REG_IZONE:  izone  <= cfg.data[hpid_pkg::MAG_W-1:0];
          hpid_pkg::REG_SETTLE: sthr   <= cfg.data[hpid_pkg::MAG_W-1:0];
          hpid_pkg::REG_WINDOW: winlen <= cfg.data[hpid_pkg::WIN_W-1:0];
          hpid_pkg::REG_TLIMIT: tlimit <= cfg.data[hpid_pkg::LIMIT_W-1:0];
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (samples.valid) begin
            state <= S_ERR;
            // begin beat restarts the turn before it is processed
            if (samples.begin_req) begin
              turn_start    <= samples.timestamp_ms;
              prev_time     <= samples.timestamp_ms;
              prev_err      <= '0;
              isum          <= '0;
              settled_count <= '0;
            end
          end
        end
        S_ERR: begin
          prev_time <= ts_r;
          state     <= S_DIFF;
        end
        S_DIFF: begin
          prev_err <= err_r;
          state    <= S_INTEG;
        end
        S_INTEG: begin
          isum          <= (mag_e_r < izone) ? isum_sat : '0;
          settled_count <= count_next;
          state         <= S_PTERM;
        end
        S_PTERM: state <= S_ITERM;
        S_ITERM: state <= S_DWAIT;
        S_DWAIT: begin
          if (!div_busy) begin
            state <= S_DTERM;
          end
        end
        S_DTERM: state <= S_MAG;
        S_MAG:   state <= S_ROUND;
        S_ROUND: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (state == S_IDLE && samples.valid) begin
      heading_r <= samples.heading;
      ts_r      <= samples.timestamp_ms;
    end
    if (state == S_ERR) begin
      err_r   <= wrapped[15:0];
      mag_e_r <= err_abs;
      dt_r    <= ts_r - prev_time;
    end
    if (state == S_DIFF) begin
      dsign   <= diff[16];
      dt_zero <= (dt_r == '0);
    end
    if (state == S_INTEG) begin
      done_r  <= (CMP_W'(count_next) >= win) || timed;
      timed_r <= timed;
    end
    if (state == S_PTERM) begin
      total <= {{7{prod[56]}}, prod};
    end
    if (state == S_ITERM) begin
      // integral product lacks the 8 fraction bits of the others, so shift it to line up
      total <= total + {prod[55:0], 8'd0};
    end
    if (state == S_DTERM) begin
      total <= total + {{7{prod[56]}}, prod};
    end
    if (state == S_MAG) begin
      neg <= total[63];
      mag <= total[63] ? 64'(-total) : 64'(total);
    end
    if (out_load) begin
      drive_q <= drive_val;
      err_q   <= err_r;
      done_q  <= done_r;
      timed_q <= timed_r;
    end
  end

  assign cfg.ready             = 1'b1;
  assign samples.ready         = (state == S_IDLE);
  assign results.valid         = out_valid;
  assign results.drive         = drive_q;
  assign results.heading_error = err_q;
  assign results.done_res      = done_q;
  assign results.timed_out     = timed_q;

  // ---------------- assertions ----------------
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_busy)
    else $error("divider still busy while sequencer idle");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.drive <= 15'sd10000 && results.drive >= -15'sd10000))
    else $error("drive beat outside saturation limits");

  a_timeout_done: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.timed_out) |-> results.done_res)
    else $error("timed out without done");

  a_izone_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_PTERM && mag_e_r >= izone) |-> (isum == '0))
    else $error("integral kept outside the integral zone");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    settled_count <= WMAX_C)
    else $error("settled count above window maximum");

endmodule

@@ tb/heading_pid_turn_controller_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heading_pid_turn_controller_test
// Drives timed heading samples and register writes into the turn controller
// and checks every result against an in-bench PID predictor. Stimulus is a
// short directed run, then converging turns with random content under several
// register settings. Both channels idle at random, and the result side holds
// off for a long stretch so that the sample channel backs up.
// ----------------------------------------------------------------------------
module heading_pid_turn_controller_test;

  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 40;
  localparam int FINAL_WAIT  = 100;
  localparam int RUN_LIMIT   = 5_000_000;
  localparam int SHOW_MAX    = 10;

  typedef struct {
    logic signed [hpid_pkg::DRIVE_W-1:0] drive;
    logic signed [hpid_pkg::ERR_W-1:0]   herr;
    logic                                done;
    logic                                tout;
  } pid_result_t;

  class pid_turn_checker;
    logic [hpid_pkg::HEADING_W-1:0]     target;
    logic signed [hpid_pkg::GAIN_W-1:0] kp, ki, kd;
    logic [hpid_pkg::MAG_W-1:0]         izone, settle;
    logic [hpid_pkg::WIN_W-1:0]         win_len;
    logic [hpid_pkg::LIMIT_W-1:0]       tlimit;

    int                          prev_err;
    logic [hpid_pkg::TIME_W-1:0] prev_t, start_t;
    int                          integ;
    int                          settled_run;

    pid_result_t due_results[$];
    int errors, samples, checked, reg_writes, done_seen, timeouts_seen;

    function new();
      target  = hpid_pkg::TARGET_RST;
      kp      = hpid_pkg::KP_RST;
      ki      = hpid_pkg::KI_RST;
      kd      = hpid_pkg::KD_RST;
      izone   = hpid_pkg::IZONE_RST;
      settle  = hpid_pkg::SETTLE_RST;
      win_len = hpid_pkg::WINDOW_RST;
      tlimit  = hpid_pkg::TLIMIT_RST;
      prev_err = 0;
      prev_t = '0;
      start_t = '0;
      integ = 0;
      settled_run = 0;
    endfunction

    function void set_reg(hpid_pkg::cfg_reg_t idx, logic [hpid_pkg::CFG_DATA_W-1:0] d);
      reg_writes++;
      case (idx)
        hpid_pkg::REG_TARGET: target  = d[hpid_pkg::HEADING_W-1:0];
        hpid_pkg::REG_KP:     kp      = d[hpid_pkg::GAIN_W-1:0];
        hpid_pkg::REG_KI:     ki      = d[hpid_pkg::GAIN_W-1:0];
        hpid_pkg::REG_KD:     kd      = d[hpid_pkg::GAIN_W-1:0];
        hpid_pkg::REG_IZONE:  izone   = d[hpid_pkg::MAG_W-1:0];
        hpid_pkg::REG_SETTLE: settle  = d[hpid_pkg::MAG_W-1:0];
        hpid_pkg::REG_WINDOW: win_len = d[hpid_pkg::WIN_W-1:0];
        hpid_pkg::REG_TLIMIT: tlimit  = d[hpid_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    // one PID step for an accepted sample
    function void step_turn(bit begin_req, logic [hpid_pkg::HEADING_W-1:0] hd_raw,
                            logic [hpid_pkg::TIME_W-1:0] ts);
      int hd, tg, err, mag, win;
      logic [hpid_pkg::TIME_W-1:0] dt, elapsed;
      longint dfix, acc, total, mag_total, r, drv;
      bit timed;
      pid_result_t want;
      samples++;
      hd = int'(hd_raw);
      hd = hd % hpid_pkg::HEADING_MOD;
      tg = int'(target);
      tg = tg % hpid_pkg::HEADING_MOD;
      if (begin_req) begin
        start_t = ts;
        prev_t = ts;
        prev_err = 0;
        integ = 0;
        settled_run = 0;
      end
      err = tg - hd;
      if (err > hpid_pkg::HALF_TURN) err -= hpid_pkg::HEADING_MOD;
      else if (err < -hpid_pkg::HALF_TURN) err += hpid_pkg::HEADING_MOD;
      mag = (err < 0) ? -err : err;

      dt = ts - prev_t;
      prev_t = ts;
      if (dt == 0) dfix = 0;
      else dfix = (longint'(err - prev_err) * 256) / longint'({32'd0, dt});
      prev_err = err;

      if (mag < izone) begin
        acc = longint'(integ) + longint'(err) * longint'({32'd0, dt});
        if (acc > longint'(32'sh7FFF_FFFF)) acc = longint'(32'sh7FFF_FFFF);
        if (acc < -longint'(64'sh8000_0000)) acc = -longint'(64'sh8000_0000);
        integ = int'(acc);
      end else begin
        integ = 0;
      end

      total = longint'(kp) * longint'(err) * 256
            + longint'(ki) * longint'(integ) * 256
            + longint'(kd) * dfix;
      // round half away from zero on the magnitude, then clamp
      mag_total = (total < 0) ? -total : total;
      r = (mag_total +
           (longint'(1) << (hpid_pkg::GAIN_FRAC_BITS + hpid_pkg::DERIV_FRAC_BITS - 1)))
          >> (hpid_pkg::GAIN_FRAC_BITS + hpid_pkg::DERIV_FRAC_BITS);
      if (r > hpid_pkg::DRIVE_MAX) r = hpid_pkg::DRIVE_MAX;
      drv = (total < 0) ? -r : r;

      if (mag < settle) begin
        if (settled_run < hpid_pkg::WINDOW_MAX_DEF) settled_run++;
      end else begin
        settled_run = 0;
      end
      win = int'(win_len);
      if (win == 0) win = 1;
      if (win > hpid_pkg::WINDOW_MAX_DEF) win = hpid_pkg::WINDOW_MAX_DEF;

      elapsed = ts - start_t;
      timed = elapsed > tlimit;

      want.drive = drv[hpid_pkg::DRIVE_W-1:0];
      want.herr  = err[hpid_pkg::ERR_W-1:0];
      want.done  = (settled_run >= win) || timed;
      want.tout  = timed;
      if (want.done) done_seen++;
      if (timed) timeouts_seen++;
      due_results.insert(due_results.size(), want);
    endfunction

    function void check_result(logic signed [hpid_pkg::DRIVE_W-1:0] drv,
                               logic signed [hpid_pkg::ERR_W-1:0] herr,
                               logic dn, logic tout);
      pid_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("%t: unexpected result: drive %0d error %0d done %0b tout %0b",
                   $realtime, drv, herr, dn, tout);
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (drv !== want.drive || herr !== want.herr || dn !== want.done ||
          tout !== want.tout) begin
        errors++;
        if (errors <= SHOW_MAX) begin
          $display("%t: result %0d mismatch (exp/act): drive %0d/%0d error %0d/%0d",
                   $realtime, checked, want.drive, drv, want.herr, herr);
          $display("    done %0b/%0b tout %0b/%0b", want.done, dn, want.tout, tout);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   quiet;
  bit   hold_pending;
  pid_turn_checker sb;

  hpid_cfg_if    cfg_ch();
  hpid_sample_if sample_ch();
  hpid_result_if result_ch();

  heading_pid_turn_controller u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .samples (sample_ch),
    .results (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("run limit reached with %0d results outstanding", sb.due_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random stalls, plus one long hold when asked
  initial begin
    int n;
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        result_ch.ready <= 1'b0;
        n = LONG_HOLD;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        result_ch.ready <= 1'b0;
        n = $urandom_range(1, 10);
      end else begin
        result_ch.ready <= 1'b1;
        n = $urandom_range(1, 20);
      end
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
      sb.check_result(result_ch.drive, result_ch.heading_error,
                      result_ch.done_res, result_ch.timed_out);
  end

  task automatic send_sample(bit b, logic [hpid_pkg::HEADING_W-1:0] hd,
                             logic [hpid_pkg::TIME_W-1:0] ts);
    sample_ch.valid        <= 1'b1;
    sample_ch.begin_req    <= b;
    sample_ch.heading      <= hd;
    sample_ch.timestamp_ms <= ts;
    do @(posedge clk); while (sample_ch.ready !== 1'b1);
    sb.step_turn(b, hd, ts);
  endtask

  task automatic idle_sender(int n);
    sample_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(hpid_pkg::cfg_reg_t idx, logic [hpid_pkg::CFG_DATA_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.set_reg(idx, d);
  endtask

  task automatic program_setting(logic [hpid_pkg::CFG_DATA_W-1:0] tgt, kp, ki, kd,
                                 iz, st, wl, tl);
    write_reg(hpid_pkg::REG_TARGET, tgt);
    write_reg(hpid_pkg::REG_KP, kp);
    write_reg(hpid_pkg::REG_KI, ki);
    write_reg(hpid_pkg::REG_KD, kd);
    write_reg(hpid_pkg::REG_IZONE, iz);
    write_reg(hpid_pkg::REG_SETTLE, st);
    write_reg(hpid_pkg::REG_WINDOW, wl);
    write_reg(hpid_pkg::REG_TLIMIT, tl);
    cfg_ch.valid <= 1'b0;
  endtask

  // block goes idle once every sample has its result back
  task automatic drain(int extra);
    sample_ch.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  function automatic logic [hpid_pkg::CFG_DATA_W-1:0] rand_gain();
    if ($urandom_range(0, 3) == 0) return hpid_pkg::CFG_DATA_W'($urandom);
    return hpid_pkg::CFG_DATA_W'($urandom_range(0, 200000) - 100000);
  endfunction

  // turns that converge on the target, with some broken beats mixed in
  task automatic run_turns(int n_items);
    int sent, steps, amp, off, tg, hsel;
    logic [hpid_pkg::TIME_W-1:0] ts, dt;
    logic [hpid_pkg::HEADING_W-1:0] hd;
    bit b;
    sent = 0;
    tg = int'(sb.target);
    tg = tg % hpid_pkg::HEADING_MOD;
    while (sent < n_items) begin
      amp = $urandom_range(0, hpid_pkg::HALF_TURN);
      steps = $urandom_range(1, 40);
      ts = $urandom;
      for (int k = 0; k < steps && sent < n_items; k++) begin
        b = (k == 0);
        if ($urandom_range(0, 9) == 0) begin
          b = ($urandom_range(0, 3) == 0);
          hd = hpid_pkg::HEADING_W'($urandom);
          ts = $urandom;
        end else begin
          off = (amp == 0) ? 0 : int'($urandom_range(0, 2 * amp)) - amp;
          hsel = (tg + off + hpid_pkg::HEADING_MOD) % hpid_pkg::HEADING_MOD;
          if ($urandom_range(0, 7) == 0 && hsel < 65536 - hpid_pkg::HEADING_MOD)
            hsel += hpid_pkg::HEADING_MOD;
          hd = hpid_pkg::HEADING_W'(hsel);
          case ($urandom_range(0, 15))
            0:       dt = '0;
            1:       dt = $urandom;
            default: dt = $urandom_range(5, 40);
          endcase
          if (k != 0) ts = ts + dt;
          amp = amp * 3 / 4;
        end
        send_sample(b, hd, ts);
        sent++;
        if (!quiet && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 10));
      end
    end
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= hpid_pkg::REG_TARGET;
    cfg_ch.data  <= '0;
    sample_ch.valid <= 1'b0;
    sample_ch.begin_req <= 1'b0;
    sample_ch.heading <= '0;
    sample_ch.timestamp_ms <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset register values; first beats run without any begin
    send_sample(1'b0, 16'd35999, 32'd5);
    send_sample(1'b0, 16'hFFFF, 32'd5);
    send_sample(1'b1, 16'd18000, 32'd1000);
    send_sample(1'b0, 16'd54000, 32'd1020);
    send_sample(1'b0, 16'd36100, 32'd1040);
    for (int i = 0; i < 11; i++) send_sample(1'b0, 16'd0, 32'd1060 + 20 * i);
    send_sample(1'b0, 16'd30000, 32'd1300);
    // past the time limit while settled
    send_sample(1'b0, 16'd0, 32'd4001);
    // timestamp wrap, then huge gaps that pin the integral at both limits
    send_sample(1'b1, 16'd35999, 32'hFFFF_FFF0);
    send_sample(1'b0, 16'd35999, 32'h0000_0010);
    send_sample(1'b0, 16'd35000, 32'h8000_0010);
    send_sample(1'b0, 16'd1000, 32'hFFFF_FFFF);
    drain(DRAIN_WAIT);

    program_setting(24'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                    24'h7FFF, 24'h7FFF, 24'h7F, 24'hFFFFF);
    run_turns(60);
    drain(DRAIN_WAIT);

    program_setting(24'd18000, 24'h800000, 24'h800000, 24'h800000,
                    24'd0, 24'd0, 24'd0, 24'd0);
    send_sample(1'b1, 16'd0, 32'd200);
    send_sample(1'b0, 16'd36000, 32'd220);
    run_turns(60);
    drain(DRAIN_WAIT);

    program_setting(hpid_pkg::CFG_DATA_W'(hpid_pkg::TARGET_RST),
                    hpid_pkg::CFG_DATA_W'(hpid_pkg::KP_RST),
                    hpid_pkg::CFG_DATA_W'(hpid_pkg::KI_RST),
                    hpid_pkg::CFG_DATA_W'(hpid_pkg::KD_RST),
                    hpid_pkg::CFG_DATA_W'(hpid_pkg::IZONE_RST),
                    hpid_pkg::CFG_DATA_W'(hpid_pkg::SETTLE_RST),
                    hpid_pkg::CFG_DATA_W'(hpid_pkg::WINDOW_RST),
                    hpid_pkg::CFG_DATA_W'(hpid_pkg::TLIMIT_RST));
    hold_pending = 1'b1;
    run_turns(100);
    drain(DRAIN_WAIT);

    for (int p = 0; p < 3; p++) begin
      program_setting(
        hpid_pkg::CFG_DATA_W'($urandom_range(0, hpid_pkg::HEADING_MOD - 1)),
        rand_gain(), rand_gain(), rand_gain(),
        hpid_pkg::CFG_DATA_W'($urandom_range(0, hpid_pkg::HALF_TURN)),
        hpid_pkg::CFG_DATA_W'($urandom_range(0, 3000)),
        hpid_pkg::CFG_DATA_W'($urandom_range(1, 64)),
        hpid_pkg::CFG_DATA_W'($urandom_range(0, 3000)));
      if (p == 0) hold_pending = 1'b1;
      if (p == 2) quiet = 1'b1;
      run_turns(p == 2 ? 80 : 90);
      drain(p == 2 ? FINAL_WAIT : DRAIN_WAIT);
    end

    $display("covered %0d samples across %0d register writes, %0d results checked",
             sb.samples, sb.reg_writes, sb.checked);
    $display("%0d results reported done, %0d by the time limit; %0d mismatches",
             sb.done_seen, sb.timeouts_seen, sb.errors);
    if (sb.errors == 0 && sb.due_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/hpid_pkg.sv
rtl/hpid_if.sv
rtl/hpid_div.sv
rtl/heading_pid_turn_controller.sv
tb/heading_pid_turn_controller_test.sv
